### sv/rbst_pkg.sv
// Package for the ray/box slab test: widths, configuration indexes and types.
// No dependencies.
package rbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int NUM_WIDTH   = DIFF_WIDTH + FRAC_BITS;
    localparam int Q_WIDTH     = COORD_WIDTH + 1;
    localparam int THR_WIDTH   = 16;
    localparam int FAR_WIDTH   = 31;
    localparam int CFG_WIDTH   = 31;
    localparam int IDX_WIDTH   = 1;
    localparam int DIV_STAGES  = NUM_WIDTH;

    localparam logic [IDX_WIDTH-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_FAR_LIMIT = 1'd1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord origin_z;
        t_coord dir_x;
        t_coord dir_y;
        t_coord dir_z;
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_ray_box;

    typedef struct packed {
        logic                 hit;
        logic [FAR_WIDTH-1:0] t_entry;
    } t_result;

    // Per-axis control that rides alongside the dividers.
    typedef struct packed {
        logic parallel;
        logic in_slab;
        logic neg_lo;
        logic neg_hi;
    } t_axis_ctl;

endpackage

### sv/rbst_if.sv
// Valid/ready channel carrying one payload beat.
// The payload type is set by parameter T; no package dependencies.
interface rbst_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/rbst_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on rbst_pkg.
module rbst_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [rbst_pkg::DIFF_WIDTH-1:0]     i_num,
    input  logic [rbst_pkg::COORD_WIDTH-1:0]    i_den,
    input  logic                                i_neg,
    output logic [rbst_pkg::Q_WIDTH-1:0]        o_mag
);
    localparam int N = rbst_pkg::NUM_WIDTH;
    localparam int D = rbst_pkg::COORD_WIDTH;
    localparam int Q = rbst_pkg::Q_WIDTH;

    logic [N-1:0] r_num [N+1];
    logic [D:0]   r_rem [N+1];
    logic [D-1:0] r_den [N+1];
    logic [Q-1:0] r_q   [N+1];
    logic         r_sat [N+1];
    logic         r_neg [N+1];

    always_comb begin
        r_num[0] = {i_num, {rbst_pkg::FRAC_BITS{1'b0}}};
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_q[0]   = '0;
        r_sat[0] = 1'b0;
        r_neg[0] = i_neg;
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [D+1:0] n_sh;
        logic [D+1:0] n_sub;
        logic         n_bit;
        logic [Q:0]   n_q;
        logic [Q-1:0] n_lim;
        always_comb begin
            n_sh  = {r_rem[s], r_num[s][N-1]};
            n_sub = n_sh - {2'b00, r_den[s]};
            n_bit = !n_sub[D+1];
            n_q   = {r_q[s], n_bit};
            n_lim = r_neg[s] ? Q'(1) << (D - 1) : (Q'(1) << (D - 1)) - Q'(1);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s] << 1;
                r_rem[s+1] <= n_bit ? n_sub[D:0] : n_sh[D:0];
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_sat[s+1] <= r_sat[s] || n_q[Q] || (n_q[Q-1:0] > n_lim);
                r_q[s+1]   <= (r_sat[s] || n_q[Q] || (n_q[Q-1:0] > n_lim))
                              ? n_lim : n_q[Q-1:0];
            end
        end
    end

    assign o_mag = r_q[N];
endmodule

### sv/ray_box_slab_test_core.sv
// Top level of the ray/box slab test: input stage, six pipelined dividers, compare stages.
// Depends on rbst_pkg, rbst_if and rbst_div.
// Path from an input beat to its result beat: setup stage, divider stages, compare stages 1 and 2.
// Throughput: one beat per cycle; the whole pipeline advances when the output register is free.
// Reset clears all valid bits and loads threshold 1 and far limit 2147483647.
module ray_box_slab_test_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbst_pkg::IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [rbst_pkg::CFG_WIDTH-1:0]    i_cfg_data,
    rbst_if.sink                              in_ch,
    rbst_if.source                            out_ch
);
    localparam int W  = rbst_pkg::COORD_WIDTH;
    localparam int Q  = rbst_pkg::Q_WIDTH;
    localparam int DS = rbst_pkg::DIV_STAGES;
    localparam int LAT = DS + 3;

    logic [rbst_pkg::THR_WIDTH-1:0] r_thr;
    logic [rbst_pkg::FAR_WIDTH-1:0] r_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rbst_pkg::THR_WIDTH'(1);
            r_far <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbst_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[rbst_pkg::THR_WIDTH-1:0];
                rbst_pkg::CFG_FAR_LIMIT: r_far <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic r_vld [LAT+1];
    logic r_out_vld;
    assign en = !r_out_vld || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 0: differences, magnitudes and parallel/in-slab tests.
    rbst_pkg::t_ray_box b;
    assign b = in_ch.data;
    logic signed [W-1:0] org [3], dir [3], lo [3], hi [3];
    always_comb begin
        org[0] = b.origin_x; org[1] = b.origin_y; org[2] = b.origin_z;
        dir[0] = b.dir_x;    dir[1] = b.dir_y;    dir[2] = b.dir_z;
        lo[0]  = b.min_x;    lo[1]  = b.min_y;    lo[2]  = b.min_z;
        hi[0]  = b.max_x;    hi[1]  = b.max_y;    hi[2]  = b.max_z;
    end

    logic [rbst_pkg::DIFF_WIDTH-1:0] r_dlo [3], r_dhi [3];
    logic [W-1:0]                    r_dm [3];
    rbst_pkg::t_axis_ctl             r_ctl0 [3];
    logic [rbst_pkg::FAR_WIDTH-1:0]  r_far0;

    for (genvar a = 0; a < 3; a++) begin : g_in
        logic signed [W:0] n_lo, n_hi;
        logic [W-1:0] n_dm;
        rbst_pkg::t_axis_ctl n_c;
        always_comb begin
            n_lo = {lo[a][W-1], lo[a]} - {org[a][W-1], org[a]};
            n_hi = {hi[a][W-1], hi[a]} - {org[a][W-1], org[a]};
            n_dm = dir[a][W-1] ? W'(-dir[a]) : W'(dir[a]);
            n_c.parallel = (n_dm == '0) || (n_dm < {{(W-rbst_pkg::THR_WIDTH){1'b0}}, r_thr});
            n_c.in_slab  = (org[a] >= lo[a]) && (org[a] <= hi[a]);
            n_c.neg_lo   = n_lo[W] != dir[a][W-1];
            n_c.neg_hi   = n_hi[W] != dir[a][W-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dlo[a]  <= n_lo[W] ? (W+1)'(-n_lo) : n_lo;
                r_dhi[a]  <= n_hi[W] ? (W+1)'(-n_hi) : n_hi;
                r_dm[a]   <= n_dm;
                r_ctl0[a] <= n_c;
            end
        end
    end
    always_ff @(posedge i_clk) if (en) r_far0 <= r_far;

    // Dividers and delay line for control and far limit.
    logic [Q-1:0] m_lo [3], m_hi [3];
    rbst_pkg::t_axis_ctl            r_ctl [DS+1][3];
    logic [rbst_pkg::FAR_WIDTH-1:0] r_fard [DS+1];
    always_comb begin
        r_ctl[0] = r_ctl0;
        r_fard[0] = r_far0;
    end
    for (genvar s = 0; s < DS; s++) begin : g_dly
        always_ff @(posedge i_clk) if (en) begin
            r_ctl[s+1]  <= r_ctl[s];
            r_fard[s+1] <= r_fard[s];
        end
    end
    for (genvar a = 0; a < 3; a++) begin : g_div
        logic [W-1:0] den;
        assign den = r_ctl0[a].parallel ? W'(1) : r_dm[a];
        rbst_div u_lo (.i_clk, .i_en(en), .i_num(r_dlo[a]), .i_den(den),
                       .i_neg(r_ctl0[a].neg_lo), .o_mag(m_lo[a]));
        rbst_div u_hi (.i_clk, .i_en(en), .i_num(r_dhi[a]), .i_den(den),
                       .i_neg(r_ctl0[a].neg_hi), .o_mag(m_hi[a]));
    end

    // Compare stage 1: sign and order per axis.
    logic signed [W:0] r_t0 [3], r_t1 [3];
    rbst_pkg::t_axis_ctl r_ctl1 [3];
    logic [rbst_pkg::FAR_WIDTH-1:0] r_far1;
    for (genvar a = 0; a < 3; a++) begin : g_ord
        logic signed [W:0] n_a, n_b;
        always_comb begin
            n_a = r_ctl[DS][a].neg_lo ? -$signed(m_lo[a]) : $signed(m_lo[a]);
            n_b = r_ctl[DS][a].neg_hi ? -$signed(m_hi[a]) : $signed(m_hi[a]);
        end
        always_ff @(posedge i_clk) if (en) begin
            r_t0[a]   <= (n_a > n_b) ? n_b : n_a;
            r_t1[a]   <= (n_a > n_b) ? n_a : n_b;
            r_ctl1[a] <= r_ctl[DS][a];
        end
    end
    always_ff @(posedge i_clk) if (en) r_far1 <= r_fard[DS];

    // Compare stage 2: running near/far over the three axes.
    rbst_pkg::t_result n_res;
    always_comb begin
        logic signed [W:0] tn, tf;
        logic h;
        tn = '0;
        tf = $signed({2'b00, r_far1});
        h  = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (h) begin
                if (r_ctl1[a].parallel) begin
                    if (!r_ctl1[a].in_slab) h = 1'b0;
                end else begin
                    if (r_t0[a] > tn) tn = r_t0[a];
                    if (r_t1[a] < tf) tf = r_t1[a];
                    if (tf < tn) h = 1'b0;
                end
            end
        end
        n_res.hit     = h;
        n_res.t_entry = h ? tn[rbst_pkg::FAR_WIDTH-1:0] : '0;
    end

    rbst_pkg::t_result r_res;
    always_ff @(posedge i_clk) begin
        if (en) r_res <= n_res;
    end

    always_comb r_vld[0] = in_ch.valid;
    for (genvar s = 0; s < LAT; s++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[s+1] <= 1'b0;
            else if (en) r_vld[s+1] <= r_vld[s];
        end
    end
    assign r_out_vld = r_vld[LAT];

    assign out_ch.valid = r_out_vld;
    assign out_ch.data  = r_res;
endmodule

### test/rbst_slab_checker.sv
// Checker for the ray/box slab test core: it watches the ray and result channels and the
// register writes, works out the expected hit and entry distance, and compares them.
// Depends on rbst_pkg and rbst_if.
module rbst_slab_checker (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [rbst_pkg::IDX_WIDTH-1:0]           i_cfg_index,
    input  logic [rbst_pkg::CFG_WIDTH-1:0]           i_cfg_data,
    rbst_if                                          ray_mon,
    rbst_if                                          res_mon,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    logic [rbst_pkg::THR_WIDTH-1:0] threshold;
    logic [rbst_pkg::FAR_WIDTH-1:0] far_limit;
    rbst_pkg::t_result              slab_result_q[$];

    // Signed distance ((bound - org) << FRAC_BITS) / dir, truncated toward zero and saturated.
    function automatic longint slab_distance(longint org, longint bound, longint dir);
        longint diff;
        longint dmag;
        longint num;
        longint quot;
        longint lim;
        bit     neg;
        diff = bound - org;
        dmag = (dir < 0) ? -dir : dir;
        neg  = (diff < 0) != (dir < 0);
        num  = ((diff < 0) ? -diff : diff) <<< rbst_pkg::FRAC_BITS;
        quot = num / dmag;
        lim  = neg ? 64'sd2147483648 : 64'sd2147483647;
        if (quot > lim) quot = lim;
        return neg ? -quot : quot;
    endfunction

    function automatic rbst_pkg::t_result slab_hit_test(rbst_pkg::t_ray_box rb);
        longint            org[3];
        longint            dir[3];
        longint            lo[3];
        longint            hi[3];
        longint            t_near;
        longint            t_far;
        longint            t0;
        longint            t1;
        longint            swap;
        longint            dmag;
        bit                hit;
        rbst_pkg::t_result res;
        org = '{longint'(rb.origin_x), longint'(rb.origin_y), longint'(rb.origin_z)};
        dir = '{longint'(rb.dir_x), longint'(rb.dir_y), longint'(rb.dir_z)};
        lo  = '{longint'(rb.min_x), longint'(rb.min_y), longint'(rb.min_z)};
        hi  = '{longint'(rb.max_x), longint'(rb.max_y), longint'(rb.max_z)};
        t_near = 0;
        t_far  = longint'(far_limit);
        hit    = 1'b1;
        for (int ax = 0; ax < 3; ax++) begin
            if (hit) begin
                dmag = (dir[ax] < 0) ? -dir[ax] : dir[ax];
                if (dmag == 0 || dmag < longint'(threshold)) begin
                    if (org[ax] < lo[ax] || org[ax] > hi[ax]) hit = 1'b0;
                end else begin
                    t0 = slab_distance(org[ax], lo[ax], dir[ax]);
                    t1 = slab_distance(org[ax], hi[ax], dir[ax]);
                    if (t0 > t1) begin
                        swap = t0;
                        t0   = t1;
                        t1   = swap;
                    end
                    if (t0 > t_near) t_near = t0;
                    if (t1 < t_far) t_far = t1;
                    if (t_far < t_near) hit = 1'b0;
                end
            end
        end
        res.hit     = hit;
        res.t_entry = hit ? t_near[rbst_pkg::FAR_WIDTH-1:0] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        rbst_pkg::t_result exp_res;
        rbst_pkg::t_result act_res;
        int                errs;
        errs = 0;
        if (!i_rst_n) begin
            threshold = 16'd1;
            far_limit = 31'h7FFF_FFFF;
            slab_result_q.delete();
            o_fail_count <= 0;
        end else begin
            if (ray_mon.valid && ray_mon.ready) begin
                slab_result_q = {slab_result_q, slab_hit_test(ray_mon.data)};
            end
            if (res_mon.valid && res_mon.ready) begin
                act_res = res_mon.data;
                if (slab_result_q.size() == 0) begin
                    $error("result beat with nothing expected: hit %0d t_entry %0d",
                           act_res.hit, act_res.t_entry);
                    errs++;
                end else begin
                    exp_res = slab_result_q.pop_front();
                    if (act_res.hit !== exp_res.hit) begin
                        $error("hit: expected %0d, actual %0d", exp_res.hit, act_res.hit);
                        errs++;
                    end
                    if (act_res.t_entry !== exp_res.t_entry) begin
                        $error("t_entry: expected %0d, actual %0d",
                               exp_res.t_entry, act_res.t_entry);
                        errs++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == rbst_pkg::CFG_THRESHOLD) begin
                    threshold = i_cfg_data[rbst_pkg::THR_WIDTH-1:0];
                end else if (i_cfg_index == rbst_pkg::CFG_FAR_LIMIT) begin
                    far_limit = i_cfg_data[rbst_pkg::FAR_WIDTH-1:0];
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= slab_result_q.size();
    end

endmodule

### test/tb_ray_box_slab_test_core.sv
// Testbench top for the ray/box slab test core: clock, reset, register phases, directed and
// random rays with random idling, and the verdict.
// Depends on rbst_pkg, rbst_if, ray_box_slab_test_core and rbst_slab_checker.
module tb_ray_box_slab_test_core;

    localparam int RAND_ITEMS = 1930;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [rbst_pkg::IDX_WIDTH-1:0] cfg_index = '0;
    logic [rbst_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    int                             fail_count;
    int                             pending;
    int                             idle_cycles = 0;
    bit                             hold_req = 1'b0;
    bit                             no_idle = 1'b0;

    rbst_if #(.T(rbst_pkg::t_ray_box)) ray_ch ();
    rbst_if #(.T(rbst_pkg::t_result))  res_ch ();

    ray_box_slab_test_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .in_ch      (ray_ch),
        .out_ch     (res_ch)
    );

    rbst_slab_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .ray_mon     (ray_ch),
        .res_mon     (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        ray_ch.valid = 1'b0;
        ray_ch.data  = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls per beat, and one long hold-off on request.
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    task automatic send_ray(rbst_pkg::t_ray_box rb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ray_ch.valid <= 1'b1;
        ray_ch.data  <= rb;
        do @(posedge i_clk); while (!ray_ch.ready);
    endtask

    task automatic drain();
        ray_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rbst_pkg::IDX_WIDTH-1:0] idx,
                             logic [rbst_pkg::CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic rbst_pkg::t_ray_box make_ray(
        rbst_pkg::t_coord ox, rbst_pkg::t_coord oy, rbst_pkg::t_coord oz,
        rbst_pkg::t_coord dx, rbst_pkg::t_coord dy, rbst_pkg::t_coord dz,
        rbst_pkg::t_coord lx, rbst_pkg::t_coord ly, rbst_pkg::t_coord lz,
        rbst_pkg::t_coord hx, rbst_pkg::t_coord hy, rbst_pkg::t_coord hz);
        return '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
    endfunction

    function automatic rbst_pkg::t_coord clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return rbst_pkg::t_coord'(v);
    endfunction

    // A box, usually well-formed, with a ray aimed near it, or full random noise.
    function automatic rbst_pkg::t_ray_box random_ray();
        longint           lo[3];
        longint           span[3];
        longint           org[3];
        longint           dir;
        int               scale;
        rbst_pkg::t_coord c[12];
        if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 12; k++) c[k] = $urandom;
            return make_ray(c[0], c[1], c[2], c[3], c[4], c[5],
                            c[6], c[7], c[8], c[9], c[10], c[11]);
        end
        scale = $urandom_range(8, 30);
        for (int ax = 0; ax < 3; ax++) begin
            lo[ax]   = longint'($signed($urandom)) >>> (31 - scale);
            span[ax] = longint'($urandom_range(0, 1 << scale));
            if ($urandom_range(0, 15) == 0) span[ax] = -span[ax];
            org[ax]  = longint'($signed($urandom)) >>> (31 - scale + 1);
            c[ax]    = clamp_coord(org[ax]);
            c[6+ax]  = clamp_coord(lo[ax]);
            c[9+ax]  = clamp_coord(lo[ax] + span[ax]);
            dir = (lo[ax] + span[ax] / 2 - org[ax]) >>> $urandom_range(0, 8);
            case ($urandom_range(0, 11))
                0: dir = 0;
                1: dir = longint'(int'($urandom_range(0, 3))) - 2;
                2: dir = longint'($signed($urandom));
                3: dir = -dir;
                default: ;
            endcase
            c[3+ax] = clamp_coord(dir);
        end
        return make_ray(c[0], c[1], c[2], c[3], c[4], c[5],
                        c[6], c[7], c[8], c[9], c[10], c[11]);
    endfunction

    task automatic run_directed();
        rbst_pkg::t_coord mx;
        rbst_pkg::t_coord mn;
        rbst_pkg::t_coord one;
        mx  = 32'sh7FFF_FFFF;
        mn  = 32'sh8000_0000;
        one = 32'sh0001_0000;
        // Origin inside the box, unit direction.
        send_ray(make_ray(0, 0, 0, one, one, one, -one, -one, -one, one, one, one));
        // Every direction zero, inside and outside.
        send_ray(make_ray(0, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one));
        send_ray(make_ray(2 * one, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one));
        // Inverted box, parallel and not.
        send_ray(make_ray(0, 0, 0, 0, 0, 0, one, -one, -one, -one, one, one));
        send_ray(make_ray(-4 * one, 0, 0, one, 0, 0, one, -one, -one, -one, one, one));
        // Box ahead and behind.
        send_ray(make_ray(-8 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
        send_ray(make_ray(8 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
        // Distance overflow in both signs.
        send_ray(make_ray(mn, 0, 0, 1, 0, 0, mx, mn, mn, mx, mx, mx));
        send_ray(make_ray(mx, 0, 0, -1, 0, 0, mn, mn, mn, mn, mx, mx));
        send_ray(make_ray(mn, mn, mn, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_ray(make_ray(mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx));
        send_ray(make_ray(mn, mx, mn, mn, mx, -1, mn, mn, mn, mx, mx, mx));
        // Direction just below, at and above the default threshold.
        send_ray(make_ray(0, 0, 0, 1, -1, 2, -one, -one, -one, one, one, one));
        send_ray(make_ray(0, 0, 0, -1, 0, -2, one, one, one, 2 * one, 2 * one, 2 * one));
        // Box entered far away.
        send_ray(make_ray(0, 0, 0, 1, 1, 1, 32'sh4000_0000, 0, 0, mx, mx, mx));
        send_ray(make_ray(0, 0, 0, mn, mn, mn, mn, mn, mn, 0, 0, 0));
    endtask

    initial begin
        logic [rbst_pkg::THR_WIDTH-1:0] thr;
        logic [rbst_pkg::FAR_WIDTH-1:0] far;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin thr = 16'd0;     far = 31'h7FFF_FFFF; end
                1: begin thr = 16'hFFFF;  far = 31'd0;         end
                2: begin thr = 16'd1;     far = 31'h0010_0000; end
                default: begin
                    thr = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 64));
                    far = $urandom_range(0, 1) ? 31'($urandom) : 31'h7FFF_FFFF;
                end
            endcase
            write_reg(rbst_pkg::CFG_THRESHOLD, rbst_pkg::CFG_WIDTH'(thr));
            write_reg(rbst_pkg::CFG_FAR_LIMIT, rbst_pkg::CFG_WIDTH'(far));
            if (phase < 3) run_directed();
            for (int n = 0; n < RAND_ITEMS / 6; n++) begin
                if (n == 40 && phase == 3) hold_req = 1'b1;
                if (n == 100) no_idle = 1'b1;
                if (n == 180) no_idle = 1'b0;
                send_ray(random_ray());
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### ray_box_slab_test_core.f
sv/rbst_pkg.sv
sv/rbst_if.sv
sv/rbst_div.sv
sv/ray_box_slab_test_core.sv
test/rbst_slab_checker.sv
test/tb_ray_box_slab_test_core.sv
